### rtl/core/hntm_pkg.sv
// ----------------------------------------------------------------------------
// hntm_pkg: shared types and tables for the header name token matcher
// Holds the known-name list, static-table entry info and channel word types.
// ----------------------------------------------------------------------------
package hntm_pkg;

   localparam int NUM_TOKENS   = 60;
   localparam int MAX_NAME_LEN = 32;
   localparam int NAME_CHARS   = 32;
   localparam int CHAR_IDX_W   = $clog2(NAME_CHARS);
   localparam int POS_W        = 6;
   localparam int TOKEN_W      = 6;
   localparam int INDEX_W      = 7;

   localparam logic [POS_W-1:0] POS_MAX = '1;

   typedef struct packed {
      logic [7:0] name_byte;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [TOKEN_W-1:0] token_code;
      logic               found;
      logic [INDEX_W-1:0] static_index;
      logic               in_static;
   } rsp_word_type;

   // Names are right-justified: the first character sits in the highest used byte.
   localparam logic [NAME_CHARS*8-1:0] NAME_TEXT [NUM_TOKENS] = '{
      "te", "age", "date", "etag", "link", "host", "vary", "range", ":path",
      "cookie", "origin", "server", "accept", "alt-svc", ":method", ":scheme",
      "purpose", "upgrade", "referer", ":status", "if-range", "location",
      "forwarded", ":protocol", "expect-ct", "early-data", "keep-alive",
      "set-cookie", "connection", "user-agent", ":authority", "content-type",
      "last-modified", "if-none-match", "cache-control", "authorization",
      "accept-ranges", "content-length", "accept-language", "accept-encoding",
      "x-forwarded-for", "x-frame-options", "content-encoding",
      "proxy-connection", "x-xss-protection", "if-modified-since",
      "transfer-encoding", "content-disposition", "timing-allow-origin",
      "x-content-type-options", "content-security-policy",
      "upgrade-insecure-requests", "strict-transport-security",
      "access-control-allow-origin", "access-control-allow-headers",
      "access-control-allow-methods", "access-control-request-method",
      "access-control-expose-headers", "access-control-request-headers",
      "access-control-allow-credentials"
   };

   // Bit 7: a static entry exists; bits 6:0: first entry index.
   localparam logic [7:0] ENTRY_INFO [NUM_TOKENS] = '{
      8'd0,        8'h80 | 8'd2,  8'h80 | 8'd6,  8'h80 | 8'd7,  8'h80 | 8'd11,
      8'd0,        8'h80 | 8'd59, 8'h80 | 8'd55, 8'h80 | 8'd1,  8'h80 | 8'd5,
      8'h80 | 8'd90, 8'h80 | 8'd92, 8'h80 | 8'd29, 8'h80 | 8'd83, 8'h80 | 8'd15,
      8'h80 | 8'd22, 8'h80 | 8'd91, 8'd0,        8'h80 | 8'd13, 8'h80 | 8'd24,
      8'h80 | 8'd89, 8'h80 | 8'd12, 8'h80 | 8'd88, 8'd0,        8'h80 | 8'd87,
      8'h80 | 8'd86, 8'd0,        8'h80 | 8'd14, 8'd0,        8'h80 | 8'd95,
      8'h80 | 8'd0,  8'h80 | 8'd44, 8'h80 | 8'd10, 8'h80 | 8'd9,  8'h80 | 8'd36,
      8'h80 | 8'd84, 8'h80 | 8'd32, 8'h80 | 8'd4,  8'h80 | 8'd72, 8'h80 | 8'd31,
      8'h80 | 8'd96, 8'h80 | 8'd97, 8'h80 | 8'd42, 8'd0,        8'h80 | 8'd62,
      8'h80 | 8'd8,  8'd0,        8'h80 | 8'd3,  8'h80 | 8'd93, 8'h80 | 8'd61,
      8'h80 | 8'd85, 8'h80 | 8'd94, 8'h80 | 8'd56, 8'h80 | 8'd35, 8'h80 | 8'd33,
      8'h80 | 8'd76, 8'h80 | 8'd81, 8'h80 | 8'd79, 8'h80 | 8'd80, 8'h80 | 8'd73
   };

   // Length of a known name: count of nonzero bytes from the low end.
   function automatic int known_length(input int k);
      int n;
      n = 0;
      for (int i = 0; i < NAME_CHARS; i++) begin
         if (NAME_TEXT[k][i*8 +: 8] != 8'd0) begin
            n = i + 1;
         end
      end
      return n;
   endfunction

endpackage

### rtl/core/hntm_if.sv
// ----------------------------------------------------------------------------
// hntm_if: valid/ready channel
// Carries one word per handshake; payload type set per instance.
// ----------------------------------------------------------------------------
interface hntm_if import hntm_pkg::*; #(
   parameter type payload_type = req_word_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/hntm_match.sv
// ----------------------------------------------------------------------------
// hntm_match: candidate mask and name compare
// Keeps byte position and candidate mask; compares one byte against all names.
// ----------------------------------------------------------------------------
module hntm_match import hntm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   name_byte,
   input  logic         last,
   output rsp_word_type result
);

   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [NUM_TOKENS-1:0] mask_ff, mask_in;
   logic [NUM_TOKENS-1:0] keep;
   logic [NUM_TOKENS-1:0] hit;

   for (genvar k = 0; k < NUM_TOKENS; k++) begin : g_name
      localparam int LEN = known_length(k);
      logic [7:0] chr [NAME_CHARS];

      for (genvar p = 0; p < NAME_CHARS; p++) begin : g_chr
         if (p < LEN) begin : g_used
            assign chr[p] = NAME_TEXT[k][(LEN-1-p)*8 +: 8];
         end else begin : g_pad
            assign chr[p] = 8'd0;
         end
      end

      assign keep[k] = mask_ff[k]
                     && (pos_ff < POS_W'(LEN))
                     && (pos_ff < POS_W'(MAX_NAME_LEN))
                     && (chr[pos_ff[CHAR_IDX_W-1:0]] == name_byte);
      assign hit[k]  = keep[k] && (pos_ff == POS_W'(LEN - 1));
   end

   // Names are distinct, so at most one hit: OR the contributions together.
   always_comb begin
      result = '0;
      for (int k = 0; k < NUM_TOKENS; k++) begin
         if (hit[k]) begin
            result.token_code   = result.token_code | TOKEN_W'(k + 1);
            result.found        = 1'b1;
            result.static_index = result.static_index | ENTRY_INFO[k][INDEX_W-1:0];
            result.in_static    = result.in_static | ENTRY_INFO[k][7];
         end
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      mask_in = mask_ff;
      if (step) begin
         if (last) begin
            pos_in  = '0;
            mask_in = '1;
         end else begin
            pos_in  = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + POS_W'(1);
            mask_in = keep;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         mask_ff <= '1;
      end else begin
         pos_ff  <= pos_in;
         mask_ff <= mask_in;
      end
   end

endmodule

### rtl/core/header_name_token_matcher_top.sv
// ----------------------------------------------------------------------------
// header_name_token_matcher_top: header field name to token lookup
// Matches a byte-serial header name against the known-name list.
// ----------------------------------------------------------------------------
// A final byte passes from the input register via the compare to the result register.
// One name byte per cycle is taken, except while a final byte waits on the result slot.
// The input register and the result register part the two sides, so a byte is
//   taken while a result waits; a final byte stalls only when the result slot is full.
// Reset (synchronous, active high) empties both registers, clears the byte
//   position and sets every candidate bit.
module header_name_token_matcher_top import hntm_pkg::*; (
   input logic   clock,
   input logic   reset,
   hntm_if.sink   req_if,
   hntm_if.source rsp_if
);

   // Input register: holds one byte word ahead of the compare logic.
   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff,  in_byte_in;
   logic         in_last_ff,  in_last_in;

   // Result register.
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff,  out_word_in;

   logic         out_free;
   logic         s1_go;
   logic         req_take;
   rsp_word_type match_word;

   // A non-final byte never makes a result, so it always advances; a final byte
   // advances only when the result slot is empty or draining this cycle.
   assign out_free = !out_valid_ff || rsp_if.ready;
   assign s1_go    = in_valid_ff && (!in_last_ff || out_free);

   assign req_if.ready = !in_valid_ff || s1_go;
   assign req_take     = req_if.valid && req_if.ready;

   hntm_match u_match (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_go),
      .name_byte (in_byte_ff),
      .last      (in_last_ff),
      .result    (match_word)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_if.payload.name_byte;
         in_last_in  = req_if.payload.last;
      end else if (s1_go) begin
         in_valid_in = 1'b0;
      end
   end

   // Load the result on a final byte; drop it once taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (s1_go && in_last_ff) begin
         out_valid_in = 1'b1;
         out_word_in  = match_word;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_last_ff  <= in_last_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_if.valid   = out_valid_ff;
   assign rsp_if.payload = out_word_ff;

   // A full, stalled result slot with a final byte waiting must stall the input.
   a_stall_backs_up: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_if.ready && in_valid_ff && in_last_ff) |-> !req_if.ready)
      else $error("final byte advanced into a full result slot");

   // An unknown name reports all fields zero.
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_word_ff.found) |->
         (out_word_ff.token_code == '0 && !out_word_ff.in_static
          && out_word_ff.static_index == '0))
      else $error("unknown name with nonzero result fields");

   // A known name carries a token code in range.
   a_token_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.found) |->
         (out_word_ff.token_code != '0 && out_word_ff.token_code <= TOKEN_W'(NUM_TOKENS)))
      else $error("token code out of range");

   // A static entry only exists for a known name.
   a_static_needs_found: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.in_static) |-> out_word_ff.found)
      else $error("static entry reported without a match");

   // Every final byte that advances produces a result word next cycle.
   a_final_gives_word: assert property (@(posedge clock) disable iff (reset)
      (s1_go && in_last_ff) |=> out_valid_ff)
      else $error("final byte produced no result");

endmodule
